// ===== hdl/rtlz_pkg.sv =====
// Shared types, constants and command structures for the Rice-table LZ decoder.
package rtlz_pkg;

  localparam int unsigned BlobBytesDefault = 65536;
  localparam int unsigned GroupBitsDefault = 4;

  localparam int unsigned PosW    = 20;   // bit position with one "beyond" bit
  localparam int unsigned CountW  = 24;
  localparam int unsigned OffW    = 21;   // offset saturating at 2^20
  localparam int unsigned IdxW    = 34;   // up to 19 unary bits then 15 suffix bits
  localparam logic [PosW-1:0] PosLimit = 20'h80000;
  localparam logic [OffW-1:0] OffCap   = 21'h100000;

  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindPull  = 2'd2;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusRange = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  localparam logic RegRiceBits   = 1'b0;
  localparam logic RegBlobLength = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BREQ, ST_BWAIT, ST_BUSE, ST_TREQ0, ST_TREQ1, ST_TWAIT, ST_TUSE,
    ST_GEND, ST_OUT
  } rtlz_state_t;

  // Bit fetch phases: unary prefix, suffix, offset group.
  typedef enum logic [1:0] {PH_UNARY, PH_SUFFIX, PH_GROUP} rtlz_phase_t;

  typedef struct packed {
    logic        load;       // pull: copy architectural state to work regs
    logic        start;      // start item
    logic        bit_req;    // read byte of current bit
    logic        bit_use;    // consume fetched bit
    logic        tab_req0;   // read first table byte
    logic        tab_req1;   // latch first, read second
    logic        tab_use;    // latch second byte, form entry
    logic        grp_end;    // finish an offset group
    logic        emit_ok;    // commit a literal
    logic        emit_err;   // commit an error
    logic        emit_empty; // empty answer
  } rtlz_cmd_t;

  typedef struct packed {
    logic        remaining_zero;
    logic        bit_bad;     // current bit not readable
    logic        tab_bad;     // table entry not readable
    logic        bit_val;
    rtlz_phase_t phase;
    logic        suffix_done;
    logic        group_done;  // all bits of group taken
    logic        more_groups;
    logic        is_literal;
  } rtlz_stat_t;

endpackage

// ===== hdl/rtlz_ram.sv =====
// Generic single-port RAM with registered read.
module rtlz_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/rtlz_ctrl.sv =====
// Controller state machine for the Rice-table LZ decoder.
module rtlz_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_take,
  input  logic [1:0]          in_kind,
  input  logic                out_free,
  input  rtlz_pkg::rtlz_stat_t stat,
  output rtlz_pkg::rtlz_cmd_t cmd,
  output logic                idle,
  output logic                out_show
);
  import rtlz_pkg::*;

  rtlz_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    idle = 1'b0;
    out_show = 1'b0;
    case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (in_take && in_kind == KindStart) begin
          cmd.start = 1'b1;
        end else if (in_take && in_kind == KindPull) begin
          if (stat.remaining_zero) begin
            cmd.emit_empty = 1'b1;
            state_next = ST_OUT;
          end else begin
            cmd.load = 1'b1;
            state_next = ST_BREQ;
          end
        end
      end
      ST_BREQ: begin
        if (stat.phase == PH_SUFFIX && stat.suffix_done) begin
          state_next = ST_TREQ0;
        end else if (stat.bit_bad) begin
          cmd.emit_err = 1'b1;
          state_next = ST_OUT;
        end else begin
          cmd.bit_req = 1'b1;
          state_next = ST_BWAIT;
        end
      end
      ST_BWAIT: begin
        // Hold the store address so that the byte is still there when used.
        cmd.bit_req = 1'b1;
        state_next = ST_BUSE;
      end
      ST_BUSE: begin
        cmd.bit_use = 1'b1;
        if (stat.phase == PH_GROUP && stat.group_done) begin
          state_next = ST_GEND;
        end else begin
          state_next = ST_BREQ;
        end
      end
      ST_GEND: begin
        cmd.grp_end = 1'b1;
        state_next = ST_BREQ;
      end
      ST_TREQ0: begin
        if (stat.tab_bad) begin
          cmd.emit_err = 1'b1;
          state_next = ST_OUT;
        end else begin
          cmd.tab_req0 = 1'b1;
          state_next = ST_TREQ1;
        end
      end
      ST_TREQ1: begin
        cmd.tab_req1 = 1'b1;
        state_next = ST_TWAIT;
      end
      ST_TWAIT: begin
        cmd.tab_use = 1'b1;
        state_next = ST_TUSE;
      end
      ST_TUSE: begin
        if (stat.is_literal) begin
          cmd.emit_ok = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_BREQ;
        end
      end
      ST_OUT: begin
        out_show = 1'b1;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/rtlz_dp.sv =====
// Datapath of the Rice-table LZ decoder: store, positions, index and offset.
module rtlz_dp #(
  parameter int unsigned BlobBytes = rtlz_pkg::BlobBytesDefault,
  parameter int unsigned GroupBits = rtlz_pkg::GroupBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rtlz_pkg::rtlz_cmd_t         cmd,
  input  logic                        load_we,
  input  logic [15:0]                 load_address,
  input  logic [7:0]                  load_byte,
  input  logic [23:0]                 out_count,
  input  logic [18:0]                 start_bit,
  input  logic [3:0]                  rice_bits,
  input  logic [16:0]                 blob_length,
  output rtlz_pkg::rtlz_stat_t        stat,
  output logic [7:0]                  res_byte,
  output logic                        res_last,
  output logic [1:0]                  res_status
);
  import rtlz_pkg::*;

  localparam int unsigned AddrW = $clog2(BlobBytes);
  localparam int unsigned GW    = GroupBits + 1;
  localparam int unsigned GCW   = $clog2(GW + 1);

  logic [PosW-1:0]   bit_position, saved_position, pos, poff;
  logic [CountW-1:0] remaining, saved_remaining, size, psz;
  logic [IdxW-1:0]   idx;
  logic [OffW-1:0]   noff;
  logic [GW-1:0]     grp;
  logic [GCW-1:0]    gcnt;
  logic [3:0]        scnt;
  rtlz_phase_t       phase;
  logic [7:0]        tbyte0;
  logic [8:0]        entry;
  logic [2:0]        tsh;
  logic [IdxW+3:0]   tbit;
  logic [16:0]       vlen;

  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_rdata;
  logic             ram_we;
  logic [7:0]       bsel;

  // Effective length is the smaller of the register and the store size.
  assign vlen = (32'(blob_length) > BlobBytes) ? 17'(BlobBytes) : blob_length;
  assign tbit = (IdxW+4)'(idx) * (IdxW+4)'(9);

  always_comb begin
    ram_we = load_we && (32'(load_address) < BlobBytes);
    ram_addr = AddrW'(load_address);
    if (cmd.bit_req) begin
      ram_addr = AddrW'(pos[PosW-1:3]);
    end else if (cmd.tab_req0) begin
      ram_addr = AddrW'(tbit[IdxW+3:3]);
    end else if (cmd.tab_req1) begin
      ram_addr = AddrW'(tbit[IdxW+3:3] + (IdxW+1)'(1));
    end
  end

  rtlz_ram #(.Width(8), .Depth(BlobBytes)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(load_byte),
    .rdata(ram_rdata)
  );

  assign bsel = ram_rdata >> (3'd7 - pos[2:0]);
  logic [15:0] word;
  assign word = {tbyte0, ram_rdata} >> (4'd7 - {1'b0, tsh});

  always_comb begin
    stat.remaining_zero = (remaining == '0);
    stat.bit_bad = (pos >= PosLimit) || ({1'b0, pos[PosW-1:3]} >= 18'(vlen));
    stat.tab_bad = (tbit[IdxW+3:3] + (IdxW+1)'(1)) >= (IdxW+1)'(vlen);
    stat.bit_val = bsel[0];
    stat.phase = phase;
    stat.suffix_done = (scnt == rice_bits);
    stat.group_done = (32'(gcnt) == GW - 1);
    stat.more_groups = grp[GW-1];
    stat.is_literal = ~entry[8];
  end

  logic [OffW+GroupBits:0] noff_w;
  logic [OffW-1:0]   noff_fin;
  logic [GW-1:0]     grp_n;
  logic [8:0]        nsize;
  logic [CountW-1:0] size_d;
  logic [PosW:0]     pos_j;

  assign grp_n = {grp[GW-2:0], bsel[0]};
  assign noff_w = ({(GroupBits+1)'(0), noff} << GroupBits) + (OffW+GroupBits+1)'(1)
                  + (OffW+GroupBits+1)'(grp[GroupBits-1:0]);
  assign noff_fin = (noff_w > (OffW+GroupBits+1)'(OffCap)) ? OffCap : OffW'(noff_w);
  assign nsize = {1'b0, entry[7:0]} + 9'd2;
  assign size_d = size - 1'b1;

  // Position after a finished reference: advanced by the total offset less one, held at the limit.
  always_comb begin
    pos_j = {1'b0, pos} + {1'b0, PosW'(noff_fin - 1'b1)};
    if ((noff_fin - 1'b1) >= OffW'(PosLimit) || pos_j > {1'b0, PosLimit}) begin
      pos_j = {1'b0, PosLimit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= '0;
      remaining <= '0;
      saved_remaining <= '0;
      saved_position <= '0;
      phase <= PH_UNARY;
    end else begin
      if (cmd.start) begin
        remaining <= out_count;
        bit_position <= {1'b0, start_bit};
        saved_remaining <= '0;
        saved_position <= '0;
      end
      if (cmd.load) begin
        pos <= bit_position;
        size <= remaining;
        psz <= saved_remaining;
        poff <= saved_position;
        idx <= '0;
        scnt <= '0;
        phase <= PH_UNARY;
      end
      if (cmd.bit_use) begin
        pos <= pos + 1'b1;
        case (phase)
          PH_UNARY: begin
            if (bsel[0]) begin
              if (idx != '1) idx <= idx + 1'b1;
            end else begin
              phase <= PH_SUFFIX;
            end
          end
          PH_SUFFIX: begin
            idx <= {idx[IdxW-2:0], bsel[0]};
            scnt <= scnt + 1'b1;
          end
          PH_GROUP: begin
            grp <= grp_n;
            gcnt <= gcnt + 1'b1;
          end
          default: phase <= PH_UNARY;
        endcase
      end
      if (cmd.tab_req0) tsh <= tbit[2:0];
      if (cmd.tab_req1) tbyte0 <= ram_rdata;
      if (cmd.tab_use) begin
        entry <= word[8:0];
        phase <= PH_GROUP;
        noff <= '0;
        grp <= '0;
        gcnt <= '0;
      end
      if (cmd.grp_end) begin
        gcnt <= '0;
        noff <= noff_fin;
        if (!grp[GW-1]) begin
          // Last group: apply the reference.
          phase <= PH_UNARY;
          idx <= '0;
          scnt <= '0;
          pos <= pos_j[PosW-1:0];
          if (CountW'(nsize) < size) begin
            psz <= size - CountW'(nsize);
            poff <= pos;
            size <= CountW'(nsize);
          end
        end
      end
      if (cmd.emit_ok) begin
        if (size_d == '0) begin
          remaining <= psz;
          bit_position <= poff;
          saved_remaining <= '0;
          saved_position <= '0;
        end else begin
          remaining <= size_d;
          bit_position <= pos;
          saved_remaining <= psz;
          saved_position <= poff;
        end
      end
      if (cmd.emit_err) begin
        bit_position <= (pos > PosLimit) ? PosLimit : pos;
        remaining <= '0;
        saved_remaining <= '0;
        saved_position <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ok) begin
      res_byte <= entry[7:0];
      res_last <= (size_d == '0) && (psz == '0);
      res_status <= StatusOk;
    end else if (cmd.emit_err || cmd.emit_empty) begin
      res_byte <= '0;
      res_last <= 1'b0;
      res_status <= cmd.emit_err ? StatusRange : StatusEmpty;
    end
  end

  logic unused_ok;
  assign unused_ok = ^{stat.more_groups};
endmodule

// ===== hdl/rice_table_lz_decoder.sv =====
// Top level of the Rice-table LZ decoder.
//
// The slave stream carries load, start and pull transactions; tdata packs
// kind, load_address, load_byte, out_count and start_bit from bit 0 up.
// Load writes one byte into the 64 KiB store, start sets the count and the
// first bit position; neither gives a result. Every pull gives exactly one
// master transaction: out_byte, status and tlast.
// A pull steps through request, wait and use states for each bit read (prefix,
// suffix, offset groups), a group end per offset group, and two byte reads for
// each table lookup, as the single store port serves one byte per request.
// Load and start leave it idle; an empty pull shows its result in the next cycle.
// One transaction is handled at a time; tready is low while a pull decodes
// and while a result waits for master tready.
// Reset clears positions, counts and the stack; the store keeps its data and must
// be loaded before use. Configuration must be written only while idle (user-enforced).
module rice_table_lz_decoder #(
  parameter int unsigned BLOB_BYTES = rtlz_pkg::BlobBytesDefault,
  parameter int unsigned GROUP_BITS = rtlz_pkg::GroupBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // kind, load_address, load_byte, out_count, start_bit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);
  import rtlz_pkg::*;

  logic [3:0]  rice_bits;
  logic [16:0] blob_length;
  rtlz_cmd_t   cmd;
  rtlz_stat_t  stat;
  logic        idle, take;

  always_ff @(posedge clk) begin
    if (rst) begin
      rice_bits <= '0;
      blob_length <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegRiceBits) rice_bits <= cfg_data[3:0];
      else blob_length <= cfg_data;
    end
  end

  assign s_axis_tready = idle;
  assign take = s_axis_tvalid && s_axis_tready;

  rtlz_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_take (take),
    .in_kind (s_axis_tdata[1:0]),
    .out_free(m_axis_tready),
    .stat    (stat),
    .cmd     (cmd),
    .idle    (idle),
    .out_show(m_axis_tvalid)
  );

  rtlz_dp #(.BlobBytes(BLOB_BYTES), .GroupBits(GROUP_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .load_we     (take && s_axis_tdata[1:0] == KindLoad),
    .load_address(s_axis_tdata[17:2]),
    .load_byte   (s_axis_tdata[25:18]),
    .out_count   (s_axis_tdata[49:26]),
    .start_bit   (s_axis_tdata[68:50]),
    .rice_bits   (rice_bits),
    .blob_length (blob_length),
    .stat        (stat),
    .res_byte    (m_axis_tdata),
    .res_last    (m_axis_tlast),
    .res_status  (m_axis_tuser)
  );

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != StatusOk |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("error result carries data");
  a_pull_out: assert property (@(posedge clk) disable iff (rst)
    take && s_axis_tdata[1:0] == KindPull && stat.remaining_zero |=> m_axis_tvalid)
    else $error("empty pull without result");
endmodule
